// ===== rtl/itew_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and token codes for the integer to English word tokens unit.
// No dependencies; every other file imports this package.
package itew_pkg;

    localparam int VALUE_W = 32;
    localparam int CODE_W  = 6;
    localparam int DIGITS  = 10;
    localparam int CNT_W   = 5;

    typedef logic [CODE_W-1:0]   word_code_t;
    typedef logic [4*DIGITS-1:0] bcd_t;

    localparam word_code_t TOK_ZERO      = 6'd0;
    localparam word_code_t TOK_TEN       = 6'd10;
    localparam word_code_t TOK_TENS_BASE = 6'd18;
    localparam word_code_t TOK_HUNDRED   = 6'd28;
    localparam word_code_t TOK_THOUSAND  = 6'd29;
    localparam word_code_t TOK_MILLION   = 6'd30;
    localparam word_code_t TOK_BILLION   = 6'd31;
    localparam word_code_t TOK_NEGATIVE  = 6'd32;

    typedef struct packed {
        logic busy;
        logic done;
    } bcd_status_t;

    typedef struct packed {
        logic start;
        logic neg;
    } seq_ctrl_t;

endpackage

// ===== rtl/itew_bcd.sv =====
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
// Depends on itew_pkg.
module itew_bcd
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [itew_pkg::VALUE_W-1:0] bin,
    output itew_pkg::bcd_t               digits,
    output itew_pkg::bcd_status_t        status
);
    import itew_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    bcd_t               dig_reg, dig_next;
    bcd_t               adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                         : dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        dig_next  = dig_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            dig_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dig_next = {adj[4*DIGITS-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
    end

    assign digits      = dig_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== rtl/itew_seq.sv =====
`timescale 1ns / 1ps
// Token sequencer: walks the decimal digits three at a time and emits at most
// one word a step through an output register. Depends on itew_pkg.
module itew_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  itew_pkg::seq_ctrl_t  ctrl,
    input  itew_pkg::bcd_t       digits,
    input  logic                 word_stall,
    output logic                 word_valid,
    output itew_pkg::word_code_t word_code,
    output logic                 last_word,
    output logic                 busy
);
    import itew_pkg::*;

    localparam int GROUP_W   = 12;
    localparam int GRP_REG_W = 4 * GROUP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_GROUP = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [2:0] SP_HDIG  = 3'd0;
    localparam logic [2:0] SP_HWORD = 3'd1;
    localparam logic [2:0] SP_TENS  = 3'd2;
    localparam logic [2:0] SP_ONES  = 3'd3;
    localparam logic [2:0] SP_SCALE = 3'd4;

    localparam logic [1:0] LAST_GROUP = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           step_reg, step_next;
    logic [1:0]           grp_idx_reg, grp_idx_next;
    logic [GRP_REG_W-1:0] grp_reg, grp_next;
    logic                 neg_reg, neg_next;
    logic                 pend_valid_reg, pend_valid_next;
    word_code_t           pend_code_reg, pend_code_next;
    logic                 word_valid_reg, word_valid_next;
    word_code_t           word_code_reg, word_code_next;
    logic                 last_reg, last_next;

    logic [3:0]  h, t, o;
    logic        grp_nz;
    logic        cand_valid;
    word_code_t  cand_code;
    logic        out_free;
    logic        push;
    logic        push_last;

    assign h      = grp_reg[GRP_REG_W-1 -: 4];
    assign t      = grp_reg[GRP_REG_W-5 -: 4];
    assign o      = grp_reg[GRP_REG_W-9 -: 4];
    assign grp_nz = |grp_reg[GRP_REG_W-1 -: GROUP_W];

    // word produced by the current step, if any
    always_comb
    begin
        cand_valid = 1'b0;
        cand_code  = TOK_ZERO;
        if (state_reg == ST_SIGN)
        begin
            cand_valid = neg_reg || (grp_reg == '0);
            cand_code  = neg_reg ? TOK_NEGATIVE : TOK_ZERO;
        end
        else
        begin
            case (step_reg)
                SP_HDIG:
                begin
                    cand_valid = (h != 4'd0);
                    cand_code  = word_code_t'(h);
                end
                SP_HWORD:
                begin
                    cand_valid = (h != 4'd0);
                    cand_code  = TOK_HUNDRED;
                end
                SP_TENS:
                begin
                    if (t == 4'd1)
                    begin
                        cand_valid = 1'b1;
                        cand_code  = TOK_TEN + word_code_t'(o);
                    end
                    else if (t >= 4'd2)
                    begin
                        cand_valid = 1'b1;
                        cand_code  = TOK_TENS_BASE + word_code_t'(t);
                    end
                end
                SP_ONES:
                begin
                    cand_valid = (t != 4'd1) && (o != 4'd0);
                    cand_code  = word_code_t'(o);
                end
                SP_SCALE:
                begin
                    cand_valid = grp_nz && (grp_idx_reg != LAST_GROUP);
                    cand_code  = TOK_BILLION - word_code_t'(grp_idx_reg);
                end
                default:
                begin
                    cand_valid = 1'b0;
                    cand_code  = TOK_ZERO;
                end
            endcase
        end
    end

    assign out_free = !word_valid_reg || !word_stall;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        grp_idx_next    = grp_idx_reg;
        grp_next        = grp_reg;
        neg_next        = neg_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        push            = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    grp_next        = GRP_REG_W'(digits);
                    neg_next        = ctrl.neg;
                    step_next       = SP_HDIG;
                    grp_idx_next    = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_SIGN;
                end
            end
            ST_SIGN, ST_GROUP:
            begin
                if (out_free)
                begin
                    // hold each word back until the next one is found so the final one can be marked
                    if (cand_valid)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_code_next  = cand_code;
                    end
                    if (state_reg == ST_SIGN)
                    begin
                        state_next = ST_GROUP;
                    end
                    else if (step_reg == SP_SCALE)
                    begin
                        step_next    = SP_HDIG;
                        grp_next     = {grp_reg[GRP_REG_W-GROUP_W-1:0], GROUP_W'(0)};
                        grp_idx_next = grp_idx_reg + 2'd1;
                        if (grp_idx_reg == LAST_GROUP)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push            = pend_valid_reg;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        word_valid_next = word_valid_reg;
        word_code_next  = word_code_reg;
        last_next       = last_reg;
        if (push)
        begin
            word_valid_next = 1'b1;
            word_code_next  = pend_code_reg;
            last_next       = push_last;
        end
        else if (out_free)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= SP_HDIG;
            grp_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            grp_idx_reg    <= grp_idx_next;
            pend_valid_reg <= pend_valid_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg       <= grp_next;
        neg_reg       <= neg_next;
        pend_code_reg <= pend_code_next;
        word_code_reg <= word_code_next;
        last_reg      <= last_next;
    end

    assign word_valid = word_valid_reg;
    assign word_code  = word_code_reg;
    assign last_word  = last_reg;
    assign busy       = (state_reg != ST_IDLE);

endmodule

// ===== rtl/integer_to_english_word_tokens_unit.sv =====
`timescale 1ns / 1ps
// Integer to English word tokens: top level joining the bit-serial decimal
// converter and the token sequencer. Depends on itew_pkg, itew_bcd, itew_seq.
//
// Takes one signed 32-bit value and emits the English word tokens naming it,
// one word per handshake, with last_word set on the final word. With no stall
// on the word side a value goes through these steps before the next value can
// be accepted: loading the bit-serial binary to decimal converter, the
// conversion (one bit per cycle), handing the digits to the sequencer, the
// sign step, twenty sequencer steps over the four digit groups (a word leaves
// at most once per step), and a flush step to release the final word.
// value_stall stays high from acceptance until the last word has entered the
// output register; stall on the word side holds the sequencer. Reset needs no
// clearing pass.
module integer_to_english_word_tokens_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                value_valid,
    output logic                                value_stall,
    input  logic signed [itew_pkg::VALUE_W-1:0] value,
    output logic                                word_valid,
    input  logic                                word_stall,
    output itew_pkg::word_code_t                word_code,
    output logic                                last_word
);
    import itew_pkg::*;

    logic               accept;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic               neg_reg;
    bcd_t               digits;
    bcd_status_t        bcd_status;
    seq_ctrl_t          seq_ctrl;
    logic               seq_busy;

    assign accept = value_valid && !value_stall;
    assign raw    = value;
    // most negative value comes out as its unsigned magnitude
    assign mag    = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= raw[VALUE_W-1];
        end
    end

    assign value_stall    = bcd_status.busy || bcd_status.done || seq_busy;
    assign seq_ctrl.start = bcd_status.done;
    assign seq_ctrl.neg   = neg_reg;

    itew_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .bin    (mag),
        .digits (digits),
        .status (bcd_status)
    );

    itew_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (seq_ctrl),
        .digits     (digits),
        .word_stall (word_stall),
        .word_valid (word_valid),
        .word_code  (word_code),
        .last_word  (last_word),
        .busy       (seq_busy)
    );

endmodule

// ===== rtl/itew_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the integer to English word tokens unit, bound to the
// top level. Depends on itew_pkg and integer_to_english_word_tokens_unit.
module itew_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 value_valid,
    input logic                 value_stall,
    input logic                 word_valid,
    input logic                 word_stall,
    input itew_pkg::word_code_t word_code,
    input logic                 last_word
);
    import itew_pkg::*;

    // a stalled word holds
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid && $stable(word_code) && $stable(last_word))
        else $error("stalled word changed");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (word_code <= TOK_NEGATIVE))
        else $error("word code out of range");

    a_neg_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && (word_code == TOK_NEGATIVE) |-> !last_word)
        else $error("negative marked as final word");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("input not held off after acceptance");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall && last_word |=> !word_valid)
        else $error("word followed final word at once");

endmodule

bind integer_to_english_word_tokens_unit itew_checker u_itew_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .word_code   (word_code),
    .last_word   (last_word)
);

// ===== tb/integer_to_english_word_tokens_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for integer_to_english_word_tokens_unit: random and edge values in,
// word tokens out, each checked against an in-bench token predictor.
// Depends on itew_pkg and the unit itself.
module integer_to_english_word_tokens_unit_tb;
    import itew_pkg::*;

    typedef struct packed {
        word_code_t code;
        logic       last;
    } spoken_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      value_valid = 1'b0;
    logic                      value_stall;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      word_valid;
    logic                      word_stall = 1'b0;
    word_code_t                word_code;
    logic                      last_word;

    logic [VALUE_W-1:0] values_pending[$];
    spoken_word_t       words_due[$];
    logic               value_taken = 1'b0;
    int                 send_idle_pct = 0;
    int                 word_stall_pct = 0;
    logic               hold_req = 1'b0;
    logic               hold_taken = 1'b0;
    int                 hold_left = 0;
    int                 fails = 0;

    integer_to_english_word_tokens_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value       (value),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word_code   (word_code),
        .last_word   (last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Work out the tokens naming v and queue them as expected words.
    function automatic void name_value(input logic [VALUE_W-1:0] v);
        word_code_t  spoken[$];
        int unsigned mag;
        int unsigned divisor;
        int unsigned grp;
        int unsigned hund;
        int unsigned rest;
        word_code_t  scale_word;
        spoken_word_t w;
        if (v == 0)
        begin
            spoken.push_back(TOK_ZERO);
        end
        else
        begin
            mag = v;
            if (v[VALUE_W-1])
            begin
                spoken.push_back(TOK_NEGATIVE);
                mag = -v;
            end
            for (int i = 0; i < 4; i++)
            begin
                case (i)
                    0: begin divisor = 1000000000; scale_word = TOK_BILLION;  end
                    1: begin divisor = 1000000;    scale_word = TOK_MILLION;  end
                    2: begin divisor = 1000;       scale_word = TOK_THOUSAND; end
                    default: begin divisor = 1;    scale_word = TOK_ZERO;     end
                endcase
                grp = (mag / divisor) % 1000;
                if (grp != 0)
                begin
                    hund = grp / 100;
                    rest = grp % 100;
                    if (hund != 0)
                    begin
                        spoken.push_back(word_code_t'(hund));
                        spoken.push_back(TOK_HUNDRED);
                    end
                    if (rest >= 11 && rest <= 19)
                        spoken.push_back(word_code_t'(rest));
                    else if (rest == 10)
                        spoken.push_back(TOK_TEN);
                    else
                    begin
                        if (rest >= 20)
                        begin
                            spoken.push_back(TOK_TENS_BASE + word_code_t'(rest / 10));
                            rest = rest % 10;
                        end
                        if (rest != 0)
                            spoken.push_back(word_code_t'(rest));
                    end
                    // the units group carries no scale word
                    if (i < 3)
                        spoken.push_back(scale_word);
                end
            end
        end
        foreach (spoken[k])
        begin
            w.code = spoken[k];
            w.last = (k == spoken.size() - 1);
            words_due.push_back(w);
        end
    endfunction

    function automatic int unsigned pick_group();
        return $urandom_range(1) ? 0 : $urandom_range(999);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        longint             wide;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(2000);
            2:
            begin
                // sparse groups so that zero groups and lone scale words turn up
                wide = longint'($urandom_range(2)) * 1000000000
                     + longint'(pick_group()) * 1000000
                     + longint'(pick_group()) * 1000
                     + longint'(pick_group());
                v = wide[VALUE_W-1:0];
            end
            default:
            begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 0;
                    3: v = $urandom_range(20);
                    default: v = 32'h0000_0001 << $urandom_range(31);
                endcase
            end
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // Feed the unit: hold a value until taken, then offer the next or idle.
    always @(negedge clk)
    begin
        if (rst_n && (!value_valid || value_taken))
        begin
            if (values_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                value       <= values_pending.pop_front();
                value_valid <= 1'b1;
            end
            else
                value_valid <= 1'b0;
        end
    end

    // Receiver stall: random, or one long hold-off when asked for.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            word_stall <= 1'b1;
            hold_left  <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            word_stall <= 1'b1;
            hold_left  <= 400;
            hold_taken <= 1'b1;
        end
        else
            word_stall <= ($urandom_range(99) < word_stall_pct);
    end

    always @(posedge clk)
    begin
        spoken_word_t want;
        value_taken <= rst_n && value_valid && !value_stall;
        if (rst_n)
        begin
            if (value_valid && !value_stall)
                name_value(value);
            if (word_valid && !word_stall)
            begin
                if (words_due.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected word: code %0d last %0b",
                             $time, word_code, last_word);
                end
                else
                begin
                    want = words_due.pop_front();
                    if (want.code !== word_code)
                    begin
                        fails++;
                        $display("%0t: word_code mismatch: expected %0d, got %0d",
                                 $time, want.code, word_code);
                    end
                    if (want.last !== last_word)
                    begin
                        fails++;
                        $display("%0t: last_word mismatch: expected %0b, got %0b",
                                 $time, want.last, last_word);
                    end
                end
            end
        end
    end

    task automatic drain();
        while (values_pending.size() != 0 || value_valid || words_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int send_pct, input int stall_pct, input int count);
        send_idle_pct  = send_pct;
        word_stall_pct = stall_pct;
        repeat (count)
            values_pending.push_back(random_value());
        drain();
    endtask

    initial
    begin
        logic [VALUE_W-1:0] edge_values[$];
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        edge_values = '{32'd0, 32'd1, -32'sd1, 32'd10, 32'd11, 32'd19, 32'd20,
                        32'd99, 32'd100, 32'd110, 32'd115, 32'd999, 32'd1000,
                        32'd1010, 32'd1000000, 32'd1000000000, 32'h7fff_ffff,
                        32'h8000_0000, 32'd40, 32'd12345, -32'sd1000000,
                        32'd13013013, 32'd2019304050, 32'd876543, -32'sd300017};
        foreach (edge_values[k])
            values_pending.push_back(edge_values[k]);
        drain();

        random_phase(0, 0, 33);
        random_phase(72, 0, 33);
        random_phase(0, 72, 33);
        random_phase(28, 28, 33);

        // long receiver hold-off while values keep coming, to back up the input
        hold_req = 1'b1;
        random_phase(0, 0, 12);

        repeat (80) @(posedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
